@@ rtl/core/fnsm_pkg.sv @@
// Shared types, constants and key mapping for the falling note slot manager.
package fnsm_pkg;

  localparam int SLOT_COUNT_DEF = 64;
  localparam logic [15:0] GAP_RST = 16'd66;
  localparam logic [6:0] LOW_NOTE = 7'd21;
  localparam logic [6:0] HIGH_NOTE = 7'd108;
  localparam logic [31:0] LINE_Y = 32'd196;
  localparam logic [31:0] FALL_MS = 32'd1800;
  localparam logic [8:0] MIN_H = 9'd8;
  localparam logic [8:0] MAX_H = 9'd480;
  localparam logic [5:0] WHITE_KEYS = 6'd52;
  localparam logic [5:0] SHARP_KEYS = 6'd36;
  localparam logic [30:0] RECIP_225 = 31'd610839794;
  localparam logic [30:0] RECIP_49 = 31'd1402438301;
  localparam int SHIFT_225 = 37;
  localparam int SHIFT_49 = 36;
  localparam logic [7:0] WHITE_BASE = 8'd12;
  localparam logic [7:0] BLACK_BASE = 8'd9;

  typedef enum logic [2:0] {
    OC_MERGED = 3'd0,
    OC_NEW    = 3'd1,
    OC_RANGE  = 3'd2,
    OC_FULL   = 3'd3,
    OC_TICK   = 3'd4
  } outcome_t;

  typedef enum logic [2:0] {
    SRC_DUR     = 3'd0,
    SRC_HNEW    = 3'd1,
    SRC_RDH     = 3'd2,
    SRC_SPAN    = 3'd3,
    SRC_ELAPSED = 3'd4
  } mul_src_t;

  typedef enum logic {
    MUL_196  = 1'b0,
    MUL_1800 = 1'b1
  } mul_op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] start;
    logic [31:0] height;
    logic        blk;
    logic [5:0]  key;
  } slot_ent_t;

  typedef struct packed {
    logic     ld_item;
    logic     mul1;
    mul_src_t mul_src;
    mul_op_t  mul_op;
    logic     mul2;
    logic     cap_h;
    logic     cap_len;
    logic     scan_rd;
    logic     scan_free;
    logic     cap_end;
    logic     idx_inc;
    logic     set_slot;
    logic     mg_wr;
    logic     alloc_wr;
    logic     tick_eval;
    logic     res_ld;
    outcome_t res_code;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic in_range;
    logic match;
    logic grow;
    logic free_found;
    logic idx_last;
  } stat_t;

  localparam logic [2:0] WPRE [12] = '{3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3,
                                       3'd4, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6};
  localparam logic [2:0] BPRE [12] = '{3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd2,
                                       3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5};
  localparam logic [11:0] BLACK_SEMI = 12'b0101_0100_1010;

  function automatic logic [6:0] key_of(input logic [6:0] note);
    logic [3:0] oct;
    logic [6:0] semi;
    logic [7:0] w;
    logic [7:0] b;
    logic       blk;
    oct = 4'd0;
    for (int k = 1; k <= 10; k++) begin
      if (note >= 7'(12 * k)) oct = 4'(k);
    end
    semi = note - 7'({3'b0, oct} * 7'd12);
    w = 8'({4'b0, oct} * 8'd7) + {5'b0, WPRE[semi[3:0]]} - WHITE_BASE;
    b = 8'({4'b0, oct} * 8'd5) + {5'b0, BPRE[semi[3:0]]} - BLACK_BASE;
    blk = BLACK_SEMI[semi[3:0]];
    return blk ? {1'b1, b[5:0]} : {1'b0, w[5:0]};
  endfunction

endpackage

@@ rtl/core/falling_note_slot_manager.sv @@
// Top level: falling note bar pool with spawn merge/allocate and tick update.
// One item at a time; in_stall stays high from acceptance until the result beat is loaded.
// Spawn: slots are scanned in order until a merge match or the last slot, then merge or allocate.
// Tick: every slot is visited; each slot costs a store read plus a two-stage multiply.
// Out-of-range spawn: no scan is made. The slot store port and the multiplier are shared by all steps.
// Reset: all slots free, merge gap 66 ms, lit masks cleared; no clearing pass is needed.
module falling_note_slot_manager import fnsm_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [6:0]  in_note,
  input  logic [31:0] in_time_ms,
  input  logic [23:0] in_duration_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_outcome,
  output logic [5:0]  out_slot,
  output logic [51:0] out_white_lit,
  output logic [35:0] out_sharp_lit
);

  cmd_t  cmd;
  stat_t stat;

  fnsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  fnsm_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_action      (in_action),
    .in_note        (in_note),
    .in_time_ms     (in_time_ms),
    .in_duration_ms (in_duration_ms),
    .cmd            (cmd),
    .stat           (stat),
    .out_outcome    (out_outcome),
    .out_slot       (out_slot),
    .out_white_lit  (out_white_lit),
    .out_sharp_lit  (out_sharp_lit)
  );

endmodule

@@ rtl/core/fnsm_ram.sv @@
// Generic simple dual-port RAM with registered read.
module fnsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/fnsm_dp.sv @@
// Datapath: slot store, constant multiply-divide unit, scan index and result registers.
module fnsm_dp import fnsm_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_action,
  input  logic [6:0]  in_note,
  input  logic [31:0] in_time_ms,
  input  logic [23:0] in_duration_ms,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic [2:0]  out_outcome,
  output logic [5:0]  out_slot,
  output logic [51:0] out_white_lit,
  output logic [35:0] out_sharp_lit
);

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int RD = (SLOT_COUNT > 1) ? SLOT_COUNT : 2;
  localparam int EW = $bits(slot_ent_t);

  logic [15:0]           gap_r;
  logic                  tick_r;
  logic                  range_r;
  logic                  blk_r;
  logic [5:0]            key_r;
  logic [31:0]           tin_r;
  logic [23:0]           dur_r;
  logic [8:0]            h_new_r;
  logic [31:0]           len_r;
  mul_op_t               mop_r;
  logic [31:0]           m1_r;
  logic [60:0]           m2_r;
  logic [31:0]           old_end_r;
  logic [SW-1:0]         idx_r;
  logic [SW-1:0]         free_idx_r;
  logic                  free_found_r;
  logic [SLOT_COUNT-1:0] live_r;
  logic [SW-1:0]         slot_res_r;
  logic [51:0]           litw_r;
  logic [35:0]           litb_r;
  outcome_t              oc_r;
  logic [5:0]            oslot_r;
  logic [51:0]           ow_r;
  logic [35:0]           ob_r;

  slot_ent_t      rd_ent;
  slot_ent_t      wr_ent;
  logic [EW-1:0]  rdata;
  logic           ram_we;
  logic [SW-1:0]  ram_waddr;
  logic [31:0]    src;
  logic [31:0]    m1_nxt;
  logic [29:0]    ma;
  logic [30:0]    mb;
  logic [31:0]    q;
  logic [31:0]    new_end;
  logic [31:0]    old_end_c;
  logic [31:0]    top;
  logic [33:0]    reach;
  logic           past;
  logic [1:0]     st_nxt;
  logic [31:0]    mh;
  logic           live_cur;

  assign rd_ent = slot_ent_t'(rdata);
  assign live_cur = live_r[idx_r];

  always_comb begin
    case (cmd.mul_src)
      SRC_DUR:     src = {8'b0, dur_r};
      SRC_HNEW:    src = {23'b0, h_new_r};
      SRC_RDH:     src = rd_ent.height;
      SRC_SPAN:    src = new_end - rd_ent.start;
      SRC_ELAPSED: src = tin_r - rd_ent.start;
      default:     src = 32'd0;
    endcase
  end

  assign m1_nxt = (cmd.mul_op == MUL_1800) ? 32'(src * FALL_MS) : 32'(src * LINE_Y);
  assign ma = (mop_r == MUL_1800) ? m1_r[31:2] : {1'b0, m1_r[31:3]};
  assign mb = (mop_r == MUL_1800) ? RECIP_49 : RECIP_225;
  assign q = (mop_r == MUL_1800) ? 32'(m2_r >> SHIFT_49) : 32'(m2_r >> SHIFT_225);

  assign new_end = tin_r + len_r;
  assign old_end_c = rd_ent.start + q;
  assign top = (tin_r > rd_ent.start) ? (32'd0 - rd_ent.height) + q
                                      : 32'd0 - rd_ent.height;
  assign past = $signed(top) >= $signed(LINE_Y);
  assign reach = {{2{top[31]}}, top} + {{2{rd_ent.height[31]}}, rd_ent.height};
  assign st_nxt = rd_ent.status + 2'd1;
  assign mh = (q < 32'(MIN_H)) ? 32'(MIN_H) : q;

  always_comb begin
    stat.is_tick = tick_r;
    stat.in_range = range_r;
    stat.match = live_cur && (rd_ent.blk == blk_r) && (rd_ent.key == key_r) &&
                 (tin_r <= old_end_c + {16'b0, gap_r});
    stat.grow = new_end > old_end_r;
    stat.free_found = free_found_r;
    stat.idx_last = idx_r == SW'(SLOT_COUNT - 1);
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = idx_r;
    wr_ent = rd_ent;
    if (cmd.mg_wr) begin
      ram_we = 1'b1;
      wr_ent.height = mh;
    end else if (cmd.alloc_wr) begin
      ram_we = 1'b1;
      ram_waddr = free_idx_r;
      wr_ent = '{status: 2'd1, start: tin_r, height: 32'(h_new_r), blk: blk_r, key: key_r};
    end else if (cmd.tick_eval && live_cur && past) begin
      ram_we = 1'b1;
      wr_ent.status = st_nxt;
    end
  end

  fnsm_ram #(.WIDTH(EW), .DEPTH(RD)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (($clog2(RD))'(ram_waddr)),
    .wdata (wr_ent),
    .re    (cmd.scan_rd),
    .raddr (($clog2(RD))'(idx_r)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= GAP_RST;
      live_r <= '0;
      litw_r <= '0;
      litb_r <= '0;
      free_found_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        gap_r <= cfg_wr_data;
      end
      if (cmd.ld_item) begin
        idx_r <= '0;
        free_found_r <= 1'b0;
        if (in_action) begin
          litw_r <= '0;
          litb_r <= '0;
        end
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.scan_free && !live_cur && !free_found_r) begin
        free_found_r <= 1'b1;
      end
      if (cmd.alloc_wr) begin
        live_r[free_idx_r] <= 1'b1;
      end
      if (cmd.tick_eval && live_cur) begin
        if (past) begin
          if (st_nxt == 2'd0) live_r[idx_r] <= 1'b0;
        end else if ($signed(reach) >= $signed({2'b0, LINE_Y})) begin
          if (rd_ent.blk) begin
            if (rd_ent.key < SHARP_KEYS) litb_r <= litb_r | (36'd1 << rd_ent.key);
          end else begin
            if (rd_ent.key < WHITE_KEYS) litw_r <= litw_r | (52'd1 << rd_ent.key);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      tick_r <= in_action;
      range_r <= (in_note >= LOW_NOTE) && (in_note <= HIGH_NOTE);
      {blk_r, key_r} <= key_of(in_note);
      tin_r <= in_time_ms;
      dur_r <= in_duration_ms;
      slot_res_r <= '0;
    end
    if (cmd.mul1) begin
      m1_r <= m1_nxt;
      mop_r <= cmd.mul_op;
    end
    if (cmd.mul2) begin
      m2_r <= {31'b0, ma} * {30'b0, mb};
    end
    if (cmd.cap_h) begin
      h_new_r <= (q < 32'(MIN_H)) ? MIN_H : ((q > 32'(MAX_H)) ? MAX_H : q[8:0]);
    end
    if (cmd.cap_len) begin
      len_r <= q;
    end
    if (cmd.cap_end) begin
      old_end_r <= old_end_c;
    end
    if (cmd.scan_free && !live_cur && !free_found_r) begin
      free_idx_r <= idx_r;
    end
    if (cmd.set_slot) begin
      slot_res_r <= idx_r;
    end else if (cmd.alloc_wr) begin
      slot_res_r <= free_idx_r;
    end
    if (cmd.res_ld) begin
      oc_r <= cmd.res_code;
      oslot_r <= 6'(slot_res_r);
      ow_r <= litw_r;
      ob_r <= litb_r;
    end
  end

  assign out_outcome = oc_r;
  assign out_slot = oslot_r;
  assign out_white_lit = ow_r;
  assign out_sharp_lit = ob_r;

`ifndef SYNTHESIS
  a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_wr |-> !live_r[free_idx_r])
    else $error("allocation into a live slot");
  a_merge_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mg_wr |-> live_cur)
    else $error("merge into a free slot");
  a_height_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_h |=> (h_new_r >= MIN_H) && (h_new_r <= MAX_H))
    else $error("bar height outside clamp");
  a_free_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_wr |-> free_found_r)
    else $error("allocation without a free slot");
`endif

endmodule

@@ rtl/core/fnsm_ctrl.sv @@
// Controller state machine sequencing spawn scans and tick passes.
module fnsm_ctrl import fnsm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, SP_M1, SP_M2, SP_H, SP_L1, SP_L2, SP_L3,
    SC_RD, SC_DAT, SC_M2, SC_CMP, MG_CHK, MG_M2, MG_WR, S_ALLOC,
    T_RD, T_M1, T_M2, T_EV, S_FIN
  } state_t;

  state_t   state_r, state_nxt;
  outcome_t code_r, code_nxt;
  logic     out_valid_r, out_valid_nxt;

  assign in_stall = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    code_nxt = code_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.is_tick) begin
          state_nxt = T_RD;
        end else if (!stat.in_range) begin
          code_nxt = OC_RANGE;
          state_nxt = S_FIN;
        end else begin
          state_nxt = SP_M1;
        end
      end
      SP_M1: begin
        cmd.mul1 = 1'b1;
        cmd.mul_src = SRC_DUR;
        cmd.mul_op = MUL_196;
        state_nxt = SP_M2;
      end
      SP_M2: begin
        cmd.mul2 = 1'b1;
        state_nxt = SP_H;
      end
      SP_H: begin
        cmd.cap_h = 1'b1;
        state_nxt = SP_L1;
      end
      SP_L1: begin
        cmd.mul1 = 1'b1;
        cmd.mul_src = SRC_HNEW;
        cmd.mul_op = MUL_1800;
        state_nxt = SP_L2;
      end
      SP_L2: begin
        cmd.mul2 = 1'b1;
        state_nxt = SP_L3;
      end
      SP_L3: begin
        cmd.cap_len = 1'b1;
        state_nxt = SC_RD;
      end
      SC_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt = SC_DAT;
      end
      SC_DAT: begin
        cmd.mul1 = 1'b1;
        cmd.mul_src = SRC_RDH;
        cmd.mul_op = MUL_1800;
        cmd.scan_free = 1'b1;
        state_nxt = SC_M2;
      end
      SC_M2: begin
        cmd.mul2 = 1'b1;
        state_nxt = SC_CMP;
      end
      SC_CMP: begin
        cmd.cap_end = 1'b1;
        if (stat.match) begin
          state_nxt = MG_CHK;
        end else if (stat.idx_last) begin
          state_nxt = S_ALLOC;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt = SC_RD;
        end
      end
      MG_CHK: begin
        cmd.set_slot = 1'b1;
        code_nxt = OC_MERGED;
        if (stat.grow) begin
          cmd.mul1 = 1'b1;
          cmd.mul_src = SRC_SPAN;
          cmd.mul_op = MUL_196;
          state_nxt = MG_M2;
        end else begin
          state_nxt = S_FIN;
        end
      end
      MG_M2: begin
        cmd.mul2 = 1'b1;
        state_nxt = MG_WR;
      end
      MG_WR: begin
        cmd.mg_wr = 1'b1;
        state_nxt = S_FIN;
      end
      S_ALLOC: begin
        if (stat.free_found) begin
          cmd.alloc_wr = 1'b1;
          code_nxt = OC_NEW;
        end else begin
          code_nxt = OC_FULL;
        end
        state_nxt = S_FIN;
      end
      T_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt = T_M1;
      end
      T_M1: begin
        cmd.mul1 = 1'b1;
        cmd.mul_src = SRC_ELAPSED;
        cmd.mul_op = MUL_196;
        state_nxt = T_M2;
      end
      T_M2: begin
        cmd.mul2 = 1'b1;
        state_nxt = T_EV;
      end
      T_EV: begin
        cmd.tick_eval = 1'b1;
        if (stat.idx_last) begin
          code_nxt = OC_TICK;
          state_nxt = S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt = T_RD;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.res_ld = 1'b1;
          cmd.res_code = code_r;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r <= OC_TICK;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      code_r <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
